// ===== rtl/assert_macros.svh =====
// Assertion macros used by the display scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== rtl/cpsds_pkg.sv =====
// Types, constants and tables of the charlieplexed display scanner.
package cpsds_pkg;

	localparam int SEGMENT_SLOTS = 24;
	localparam logic [2:0] MAX_TEXT_CHARS = 3'd6;

	typedef enum logic [1:0] {
		FUNC_TICK   = 2'd0,
		FUNC_START  = 2'd1,
		FUNC_APPEND = 2'd2
	} func_t;

	localparam logic [7:0] CHAR_NUL  = 8'h00;
	localparam logic [7:0] CHAR_DOT  = 8'h2E;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_E    = 8'h45;

	// pin pairs per slot (digit * 8 + segment)
	localparam logic [2:0] PIN_HI [SEGMENT_SLOTS] = '{
		3'd5, 3'd4, 3'd1, 3'd6, 3'd5, 3'd2, 3'd1, 3'd2,
		3'd6, 3'd4, 3'd3, 3'd2, 3'd1, 3'd6, 3'd5, 3'd2,
		3'd6, 3'd5, 3'd3, 3'd2, 3'd1, 3'd4, 3'd3, 3'd4
	};
	localparam logic [2:0] PIN_LO [SEGMENT_SLOTS] = '{
		3'd6, 3'd6, 3'd6, 3'd1, 3'd1, 3'd1, 3'd2, 3'd6,
		3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd2, 3'd2, 3'd3,
		3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd2, 3'd2, 3'd3
	};

	// seven-segment pattern, bit j = segment j; unknown characters are blank
	function automatic logic [6:0] digit_shape(input logic [7:0] c);
		logic [6:0] s;
		unique case (c)
			8'h30: s = 7'h3F;
			8'h31: s = 7'h06;
			8'h32: s = 7'h5B;
			8'h33: s = 7'h4F;
			8'h34: s = 7'h66;
			8'h35: s = 7'h6D;
			8'h36: s = 7'h7D;
			8'h37: s = 7'h07;
			8'h38: s = 7'h7F;
			8'h39: s = 7'h6F;
			CHAR_E: s = 7'h79;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/cpsds_in_if.sv =====
// Command channel of the display scanner: valid/ready plus func and character.
interface cpsds_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] char_code;

	modport source (output valid, output func, output char_code, input ready);
	modport sink (input valid, input func, input char_code, output ready);
endinterface

// ===== rtl/cpsds_out_if.sv =====
// Pin drive channel of the display scanner: valid/ready plus the pin pair.
interface cpsds_out_if;
	logic       valid;
	logic       ready;
	logic       drive_active;
	logic [2:0] high_pin;
	logic [2:0] low_pin;

	modport source (output valid, output drive_active, output high_pin, output low_pin,
		input ready);
	modport sink (input valid, input drive_active, input high_pin, input low_pin,
		output ready);
endinterface

// ===== rtl/charlieplex_segment_display_scanner_core.sv =====
// Top level of the charlieplexed three-digit seven-segment display scanner.
//
//  channel | dir | fields                          | item
//  cmd     | in  | func, char_code                 | tick, start of text or character
//  disp    | out | drive_active, high_pin, low_pin | pin pair for one refresh tick
//
// One item per cycle while no tick is held by a full output register: a command is
// registered, then decoded against the display state; a tick writes the output register.
// A tick passes the input register and then the result register to reach the pin pair.
// Reset clears the display state; the refresh rank restarts at zero.
// A tick waits in the input register only while the output register is full
// and not taken; other commands never stall.
`include "assert_macros.svh"

module charlieplex_segment_display_scanner_core (
	input logic         clk,
	input logic         arst_n,
	cpsds_in_if.sink    cmd,
	cpsds_out_if.source disp
);

	localparam int NS = cpsds_pkg::SEGMENT_SLOTS;

	// input register
	logic                 valid_s1;
	cpsds_pkg::func_t     func_s1;
	logic [7:0]           char_s1;

	// display state
	logic [NS-1:0] lit_mask_q;
	logic [4:0]    lit_count_q;
	logic [4:0]    refresh_index_q;
	logic [1:0]    digit_unit_q;
	logic          last_was_dot_q;
	logic          text_full_q;
	logic [2:0]    chars_taken_q;

	// result register
	logic       out_valid_q;
	logic       drive_active_q;
	logic [2:0] high_pin_q;
	logic [2:0] low_pin_q;

	logic is_tick, advance;

	assign is_tick = (func_s1 == cpsds_pkg::FUNC_TICK);
	assign advance = valid_s1 && (!is_tick || !out_valid_q || disp.ready);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			func_s1 <= cpsds_pkg::func_t'(cmd.func);
			char_s1 <= cmd.char_code;
		end
	end

	// ---------------- character append ----------------
	logic          app_blocked, app_is_dot, app_full;
	logic [2:0]    app_unit;
	logic [NS-1:0] app_bits, app_mask;
	logic [4:0]    app_count;

	always_comb begin
		app_blocked = text_full_q || (chars_taken_q >= cpsds_pkg::MAX_TEXT_CHARS);
		app_is_dot  = (char_s1 == cpsds_pkg::CHAR_DOT);
		// a dot lands on the current digit, a digit after a digit on the next one
		if (app_is_dot) begin
			app_unit = {1'b0, digit_unit_q};
		end else begin
			app_unit = {1'b0, digit_unit_q} + {2'b00, !last_was_dot_q};
		end
		app_full = (app_unit > 3'd2);
		if (app_is_dot) begin
			app_bits = NS'(1) << {app_unit[1:0], 3'b111};
		end else begin
			app_bits = NS'(cpsds_pkg::digit_shape(char_s1)) << {app_unit[1:0], 3'b000};
		end
		app_mask  = lit_mask_q | app_bits;
		app_count = 5'($countones(app_mask));
	end

	// ---------------- refresh selection ----------------
	logic [4:0] idx_eff;
	logic       sel_any;
	logic [2:0] sel_hi, sel_lo;

	always_comb begin
		idx_eff = (refresh_index_q >= lit_count_q) ? 5'd0 : refresh_index_q;
		sel_any = 1'b0;
		sel_hi  = 3'd0;
		sel_lo  = 3'd0;
		// each slot independently checks whether it is the idx_eff-th lit one
		for (int i = 0; i < NS; i++) begin
			if (lit_mask_q[i] &&
				(5'($countones(lit_mask_q & ((NS'(1) << i) - NS'(1)))) == idx_eff)) begin
				sel_any = 1'b1;
				sel_hi  = sel_hi | cpsds_pkg::PIN_HI[i];
				sel_lo  = sel_lo | cpsds_pkg::PIN_LO[i];
			end
		end
	end

	// ---------------- state update ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_mask_q      <= '0;
			lit_count_q     <= 5'd0;
			refresh_index_q <= 5'd0;
			digit_unit_q    <= 2'd0;
			last_was_dot_q  <= 1'b1;
			text_full_q     <= 1'b0;
			chars_taken_q   <= 3'd0;
		end else if (advance) begin
			unique case (func_s1)
				cpsds_pkg::FUNC_TICK: begin
					refresh_index_q <= (lit_count_q == 5'd0) ? 5'd0 : idx_eff + 5'd1;
				end
				cpsds_pkg::FUNC_START: begin
					lit_mask_q     <= '0;
					lit_count_q    <= 5'd0;
					digit_unit_q   <= 2'd0;
					last_was_dot_q <= 1'b1;
					text_full_q    <= 1'b0;
					chars_taken_q  <= 3'd0;
				end
				cpsds_pkg::FUNC_APPEND: begin
					if (!app_blocked) begin
						if (char_s1 == cpsds_pkg::CHAR_NUL) begin
							text_full_q <= 1'b1;
						end else begin
							chars_taken_q <= chars_taken_q + 3'd1;
							if (app_full) begin
								text_full_q <= 1'b1;
							end else begin
								lit_mask_q     <= app_mask;
								lit_count_q    <= app_count;
								last_was_dot_q <= app_is_dot;
								digit_unit_q   <= app_is_dot ? app_unit[1:0] + 2'd1
									: app_unit[1:0];
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_tick) begin
			out_valid_q <= 1'b1;
		end else if (disp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_tick) begin
			drive_active_q <= sel_any;
			high_pin_q     <= sel_hi;
			low_pin_q      <= sel_lo;
		end
	end

	assign disp.valid        = out_valid_q;
	assign disp.drive_active = drive_active_q;
	assign disp.high_pin     = high_pin_q;
	assign disp.low_pin      = low_pin_q;

	// ---------------- assertions ----------------
	`ASSERT_AT(a_count_matches_mask, clk, arst_n, lit_count_q == 5'($countones(lit_mask_q)))
	`ASSERT_AT(a_chars_bounded, clk, arst_n, chars_taken_q <= cpsds_pkg::MAX_TEXT_CHARS)
	`ASSERT_AT(a_idle_pins_zero, clk, arst_n,
		(out_valid_q && !drive_active_q) |-> (high_pin_q == 3'd0 && low_pin_q == 3'd0))
	`ASSERT_AT(a_active_pins_distinct, clk, arst_n,
		(out_valid_q && drive_active_q) |->
		(high_pin_q != low_pin_q && high_pin_q != 3'd0 && low_pin_q != 3'd0))
	`ASSERT_AT(a_result_from_tick, clk, arst_n,
		$rose(out_valid_q) |-> $past(advance && is_tick))

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the charlieplexed seven-segment display scanner.
`timescale 1ns / 1ps

module tb_top;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int RAND_ITEMS = 1550;
	localparam int HOLDOFF_CYCLES = 60;

	typedef struct packed {
		logic       drive_active;
		logic [2:0] high_pin;
		logic [2:0] low_pin;
	} pin_pair_t;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] char_code;
		logic       known;
		pin_pair_t  pair;
	} cmd_row_t;

	localparam logic [6:0] SEG_SHAPES [10] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
	};
	localparam logic [6:0] SHAPE_E = 7'h79;
	localparam logic [2:0] SCAN_HI_PIN [24] = '{
		3'd5, 3'd4, 3'd1, 3'd6, 3'd5, 3'd2, 3'd1, 3'd2,
		3'd6, 3'd4, 3'd3, 3'd2, 3'd1, 3'd6, 3'd5, 3'd2,
		3'd6, 3'd5, 3'd3, 3'd2, 3'd1, 3'd4, 3'd3, 3'd4
	};
	localparam logic [2:0] SCAN_LO_PIN [24] = '{
		3'd6, 3'd6, 3'd6, 3'd1, 3'd1, 3'd1, 3'd2, 3'd6,
		3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd2, 3'd2, 3'd3,
		3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd2, 3'd2, 3'd3
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cpsds_in_if  cmd_ch ();
	cpsds_out_if disp_ch ();

	charlieplex_segment_display_scanner_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.disp   (disp_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predicted display state
	logic [23:0] disp_mask;
	logic [4:0]  disp_count;
	logic [4:0]  scan_rank;
	logic [1:0]  digit_pos;
	logic        dot_seen;
	logic        text_closed;
	logic [2:0]  char_count;

	pin_pair_t pending_pairs [$];
	cmd_row_t  directed_rows [26];
	int cmds_sent = 0;
	int pairs_seen = 0;
	int lit_pairs = 0;
	int starts_sent = 0;
	int chars_sent = 0;
	int errors = 0;
	bit held_off = 0;

	function automatic void clear_text();
		disp_mask = '0;
		disp_count = '0;
		digit_pos = '0;
		dot_seen = 1'b1;
		text_closed = 1'b0;
		char_count = '0;
	endfunction

	function automatic void light(int slot);
		if (!disp_mask[slot]) begin
			disp_mask[slot] = 1'b1;
			disp_count = disp_count + 5'd1;
		end
	endfunction

	function automatic void add_char(logic [7:0] c);
		int pos;
		logic [6:0] shape;
		if (text_closed || char_count >= cpsds_pkg::MAX_TEXT_CHARS)
			return;
		if (c == cpsds_pkg::CHAR_NUL) begin
			text_closed = 1'b1;
			return;
		end
		char_count = char_count + 3'd1;
		if (c == cpsds_pkg::CHAR_DOT) begin
			if (digit_pos > 2'd2) begin
				text_closed = 1'b1;
				return;
			end
			light(int'(digit_pos) * 8 + 7);
			dot_seen = 1'b1;
			digit_pos = digit_pos + 2'd1;
			return;
		end
		// a digit right after a digit moves on to the next position
		pos = int'(digit_pos) + (dot_seen ? 0 : 1);
		if (pos > 2) begin
			text_closed = 1'b1;
			return;
		end
		digit_pos = pos[1:0];
		if (c >= cpsds_pkg::CHAR_ZERO && c <= cpsds_pkg::CHAR_NINE)
			shape = SEG_SHAPES[c - cpsds_pkg::CHAR_ZERO];
		else if (c == cpsds_pkg::CHAR_E)
			shape = SHAPE_E;
		else
			shape = '0;
		for (int j = 0; j < 7; j++)
			if (shape[j])
				light(pos * 8 + j);
		dot_seen = 1'b0;
	endfunction

	function automatic pin_pair_t next_pair();
		pin_pair_t p;
		int rank;
		bit found;
		p = '0;
		rank = 0;
		found = 0;
		if (scan_rank >= disp_count)
			scan_rank = '0;
		if (disp_count == 0)
			return p;
		for (int slot = 0; slot < cpsds_pkg::SEGMENT_SLOTS; slot++) begin
			if (disp_mask[slot] && !found) begin
				if (rank == int'(scan_rank)) begin
					p = '{1'b1, SCAN_HI_PIN[slot], SCAN_LO_PIN[slot]};
					found = 1;
				end
				rank++;
			end
		end
		scan_rank = scan_rank + 5'd1;
		return p;
	endfunction

	function automatic void take_cmd(logic [1:0] f, logic [7:0] c, logic known,
		pin_pair_t typed);
		pin_pair_t p;
		case (f)
			cpsds_pkg::FUNC_START: begin
				clear_text();
				starts_sent++;
			end
			cpsds_pkg::FUNC_APPEND: begin
				add_char(c);
				chars_sent++;
			end
			cpsds_pkg::FUNC_TICK: begin
				p = next_pair();
				pending_pairs.push_back(known ? typed : p);
			end
			default: ;
		endcase
	endfunction

	// idle draw with calm stretches where the side never waits
	function automatic int draw_gap(int n);
		return ((n / 100) % 3 == 2) ? 0 : int'($urandom_range(0, 3));
	endfunction

	task automatic offer_cmd(logic [1:0] f, logic [7:0] c, logic known, pin_pair_t typed);
		int gap;
		gap = draw_gap(cmds_sent);
		if (gap > 0) begin
			cmd_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid = 1'b1;
		cmd_ch.func = f;
		cmd_ch.char_code = c;
		do @(posedge clk); while (!cmd_ch.ready);
		take_cmd(f, c, known, typed);
		cmds_sent++;
		@(negedge clk);
	endtask

	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.func = cpsds_pkg::FUNC_TICK;
		cmd_ch.char_code = '0;
		disp_ch.ready = 1'b0;
		scan_rank = '0;
		clear_text();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		#5ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// result checker
	always @(posedge clk) begin
		pin_pair_t want;
		if (arst_n && disp_ch.valid && disp_ch.ready) begin
			pairs_seen++;
			if (disp_ch.drive_active)
				lit_pairs++;
			if (pending_pairs.size() == 0) begin
				$error("pin pair with no item pending: active %0d high %0d low %0d",
					disp_ch.drive_active, disp_ch.high_pin, disp_ch.low_pin);
				errors++;
			end else begin
				want = pending_pairs.pop_front();
				if (disp_ch.drive_active !== want.drive_active) begin
					$error("drive_active expected %0d got %0d", want.drive_active,
						disp_ch.drive_active);
					errors++;
				end
				if (disp_ch.high_pin !== want.high_pin) begin
					$error("high_pin expected %0d got %0d", want.high_pin, disp_ch.high_pin);
					errors++;
				end
				if (disp_ch.low_pin !== want.low_pin) begin
					$error("low_pin expected %0d got %0d", want.low_pin, disp_ch.low_pin);
					errors++;
				end
			end
		end
	end

	// receiver: random stalls, one long hold-off to back the block up
	initial begin
		int gap;
		wait (arst_n);
		@(negedge clk);
		forever begin
			gap = draw_gap(pairs_seen);
			if (!held_off && pairs_seen >= 300) begin
				held_off = 1;
				gap = HOLDOFF_CYCLES;
			end
			if (gap > 0) begin
				disp_ch.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			disp_ch.ready = 1'b1;
			do @(posedge clk); while (!disp_ch.valid);
			@(negedge clk);
		end
	end

	// sender: directed table, then random text sequences and noise
	initial begin
		int n;
		int pick;
		bit drained;
		logic [7:0] c;
		drained = 0;
		directed_rows = '{
			'{cpsds_pkg::FUNC_TICK,   8'h00, 1'b1, '{1'b0, 3'd0, 3'd0}},
			'{FUNC_UNUSED,            8'hFF, 1'b0, '0},
			'{cpsds_pkg::FUNC_START,  8'h00, 1'b0, '0},
			'{cpsds_pkg::FUNC_APPEND, 8'h38, 1'b0, '0},
			'{cpsds_pkg::FUNC_TICK,   8'h00, 1'b1, '{1'b1, 3'd5, 3'd6}},
			'{cpsds_pkg::FUNC_TICK,   8'hFF, 1'b1, '{1'b1, 3'd4, 3'd6}},
			'{cpsds_pkg::FUNC_APPEND, cpsds_pkg::CHAR_DOT, 1'b0, '0},
			'{cpsds_pkg::FUNC_APPEND, cpsds_pkg::CHAR_E, 1'b0, '0},
			'{cpsds_pkg::FUNC_APPEND, cpsds_pkg::CHAR_NINE, 1'b0, '0},
			'{cpsds_pkg::FUNC_APPEND, cpsds_pkg::CHAR_DOT, 1'b0, '0},
			'{cpsds_pkg::FUNC_APPEND, 8'h31, 1'b0, '0},
			'{cpsds_pkg::FUNC_TICK,   8'h00, 1'b0, '0},
			'{cpsds_pkg::FUNC_START,  8'hFF, 1'b0, '0},
			'{cpsds_pkg::FUNC_TICK,   8'h00, 1'b1, '{1'b0, 3'd0, 3'd0}},
			'{cpsds_pkg::FUNC_APPEND, 8'hFF, 1'b0, '0},
			'{cpsds_pkg::FUNC_APPEND, cpsds_pkg::CHAR_NUL, 1'b0, '0},
			'{cpsds_pkg::FUNC_APPEND, 8'h35, 1'b0, '0},
			'{cpsds_pkg::FUNC_TICK,   8'h00, 1'b1, '{1'b0, 3'd0, 3'd0}},
			'{cpsds_pkg::FUNC_START,  8'h00, 1'b0, '0},
			'{cpsds_pkg::FUNC_APPEND, 8'h31, 1'b0, '0},
			'{cpsds_pkg::FUNC_APPEND, cpsds_pkg::CHAR_DOT, 1'b0, '0},
			'{cpsds_pkg::FUNC_APPEND, 8'h32, 1'b0, '0},
			'{cpsds_pkg::FUNC_APPEND, cpsds_pkg::CHAR_DOT, 1'b0, '0},
			'{cpsds_pkg::FUNC_APPEND, cpsds_pkg::CHAR_ZERO, 1'b0, '0},
			'{cpsds_pkg::FUNC_APPEND, cpsds_pkg::CHAR_DOT, 1'b0, '0},
			'{cpsds_pkg::FUNC_APPEND, cpsds_pkg::CHAR_DOT, 1'b0, '0}
		};
		wait (arst_n);
		@(negedge clk);
		foreach (directed_rows[i])
			offer_cmd(directed_rows[i].func, directed_rows[i].char_code,
				directed_rows[i].known, directed_rows[i].pair);
		repeat (4) offer_cmd(cpsds_pkg::FUNC_TICK, 8'h00, 1'b0, '0);

		while (cmds_sent < RAND_ITEMS) begin
			if (!drained && cmds_sent >= 800) begin
				// let the block empty out completely before going on
				drained = 1;
				cmd_ch.valid = 1'b0;
				while (pending_pairs.size() != 0)
					@(negedge clk);
			end
			if ($urandom_range(0, 4) != 0) begin
				offer_cmd(cpsds_pkg::FUNC_START, 8'($urandom_range(0, 255)), 1'b0, '0);
				n = $urandom_range(1, 8);
				for (int k = 0; k < n; k++) begin
					repeat ($urandom_range(0, 2))
						offer_cmd(cpsds_pkg::FUNC_TICK, 8'($urandom_range(0, 255)),
							1'b0, '0);
					pick = $urandom_range(0, 19);
					if (pick < 8)
						c = cpsds_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
					else if (pick < 10)
						c = cpsds_pkg::CHAR_E;
					else if (pick < 15)
						c = cpsds_pkg::CHAR_DOT;
					else if (pick < 16)
						c = cpsds_pkg::CHAR_NUL;
					else
						c = 8'($urandom_range(0, 255));
					offer_cmd(cpsds_pkg::FUNC_APPEND, c, 1'b0, '0);
				end
				repeat ($urandom_range(2, 14))
					offer_cmd(cpsds_pkg::FUNC_TICK, 8'($urandom_range(0, 255)), 1'b0, '0);
			end else begin
				offer_cmd(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0, '0);
			end
		end
		cmd_ch.valid = 1'b0;

		while (pending_pairs.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("Sent %0d commands (%0d text starts, %0d characters).",
			cmds_sent, starts_sent, chars_sent);
		$display("Checked %0d pin pairs, %0d of them driving a segment.",
			pairs_seen, lit_pairs);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== charlieplex_segment_display_scanner_core.f =====
+incdir+rtl
rtl/cpsds_pkg.sv
rtl/cpsds_in_if.sv
rtl/cpsds_out_if.sv
rtl/charlieplex_segment_display_scanner_core.sv
verif/tb_top.sv
